// ----- rtl/core/ssd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and fixed output widths for the segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

	// Output field widths are fixed by the result item format.
	localparam int OUT_COORD_W = 16;
	localparam int DIST_W      = 21;
	localparam int N_CAND      = 4;

	// Where the nearest point of one candidate projection comes from.
	typedef enum logic [1:0] {
		FOOT_START = 2'd0,
		FOOT_END   = 2'd1,
		FOOT_MID   = 2'd2
	} foot_sel_t;

endpackage

// ----- rtl/core/segment_to_segment_distance_unit.sv -----
// Throughput: one item per cycle while the output is not stalled; the whole pipeline advances together.
// The rate is set by the divider cell rows (one quotient bit per cell) and the
// square root cell row (one root bit per cell), all fully pipelined.
// Reset clears only the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_to_segment_distance_unit
// Minimum distance between two 2D integer segments, with nearest points and a
// proper crossing flag, computed in a pipeline of division and root cells.
// ----------------------------------------------------------------------------
module segment_to_segment_distance_unit #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Fields from bit 0 up: seg_a_start_x, seg_a_start_y, seg_a_end_x,
	// seg_a_end_y, seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y.
	input  logic [8*COORD_BITS-1:0] s_axis_tdata,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// Fields from bit 0 up: gap_distance (21), near_a_x, near_a_y, near_b_x,
	// near_b_y (16 each), then three zero bits.
	output logic [87:0]             m_axis_tdata,
	// Fields from bit 0 up: crossing.
	output logic                    m_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready
);

	localparam int C    = COORD_BITS;
	localparam int PW   = 2*C + 2;       // product of two coordinate differences
	localparam int SW   = 2*C + 4;       // signed sums of products
	localparam int DVW  = 2*C + 3;       // divisor and numerator magnitude
	localparam int AW   = C + 1;         // direction magnitude
	localparam int NW   = DVW + AW;      // dividend
	localparam int QW   = C + 1;         // quotient, bounded by the direction
	localparam int FW   = C + 3;         // foot arithmetic
	localparam int DQW  = 2*C + 3;       // squared candidate distance
	localparam int SQI  = DQW + 2*FRAC_BITS + 1;
	localparam int RB   = SQI / 2;
	localparam int LAT  = 11 + QW + RB;
	localparam int SDW  = 8*C + 1 + 8 + 8;
	localparam int S2W  = 4*C + 1;
	localparam int OCW  = ssd_pkg::OUT_COORD_W;
	localparam int DSW  = ssd_pkg::DIST_W;

	// Pipeline control: every stage moves when the output slot is free.
	logic           en;
	logic [LAT-1:0] vld_q;

	assign en            = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	// Stage 1: input register. Point order a0, a1, b0, b1; axis 0 is x.
	logic signed [C-1:0] pt_s1 [4][2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int a = 0; a < 2; a++) begin
					pt_s1[i][a] <= s_axis_tdata[(2*i+a)*C +: C];
				end
			end
		end
	end

	// Stage 2: direction vectors, offsets and all products.
	// Candidate k projects point k onto segment B (k < 2) or segment A.
	logic signed [C:0]    sd_c [2][2];
	logic signed [C:0]    dp_c [4][2];
	logic signed [C-1:0]  pt_s2 [4][2];
	logic signed [C:0]    sd_s2 [2][2];
	logic signed [PW-1:0] mn_s2 [4][2];
	logic signed [PW-1:0] ls_s2 [2][2];
	logic signed [PW-1:0] den1_s2, den2_s2, ns1_s2, ns2_s2, nt1_s2, nt2_s2;

	always_comb begin
		for (int g = 0; g < 2; g++) begin
			for (int a = 0; a < 2; a++) begin
				sd_c[g][a] = {pt_s1[2*g+1][a][C-1], pt_s1[2*g+1][a]}
					- {pt_s1[2*g][a][C-1], pt_s1[2*g][a]};
			end
		end
		for (int k = 0; k < 4; k++) begin
			for (int a = 0; a < 2; a++) begin
				dp_c[k][a] = {pt_s1[k][a][C-1], pt_s1[k][a]}
					- {pt_s1[(k < 2) ? 2 : 0][a][C-1], pt_s1[(k < 2) ? 2 : 0][a]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s2 <= pt_s1;
			sd_s2 <= sd_c;
			for (int k = 0; k < 4; k++) begin
				for (int a = 0; a < 2; a++) begin
					mn_s2[k][a] <= dp_c[k][a] * sd_c[(k < 2) ? 1 : 0][a];
				end
			end
			for (int g = 0; g < 2; g++) begin
				for (int a = 0; a < 2; a++) begin
					ls_s2[g][a] <= sd_c[g][a] * sd_c[g][a];
				end
			end
			// Cross product and the two line parameter numerators; the
			// offset b0 - a0 is candidate two's offset.
			den1_s2 <= sd_c[1][0] * sd_c[0][1];
			den2_s2 <= sd_c[1][1] * sd_c[0][0];
			ns1_s2  <= sd_c[0][0] * dp_c[2][1];
			ns2_s2  <= sd_c[0][1] * dp_c[2][0];
			nt1_s2  <= sd_c[1][1] * dp_c[2][0];
			nt2_s2  <= sd_c[1][0] * dp_c[2][1];
		end
	end

	// Stage 3: sums of products.
	logic signed [C-1:0]  pt_s3 [4][2];
	logic signed [C:0]    sd_s3 [2][2];
	logic signed [SW-1:0] n_s3 [4];
	logic [DVW-1:0]       len_s3 [2];
	logic signed [SW-1:0] den_s3, ns_s3, nt_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s3 <= pt_s2;
			sd_s3 <= sd_s2;
			for (int k = 0; k < 4; k++) begin
				n_s3[k] <= SW'(mn_s2[k][0]) + SW'(mn_s2[k][1]);
			end
			for (int g = 0; g < 2; g++) begin
				len_s3[g] <= DVW'(ls_s2[g][0]) + DVW'(ls_s2[g][1]);
			end
			den_s3 <= SW'(den1_s2) - SW'(den2_s2);
			ns_s3  <= SW'(ns1_s2) - SW'(ns2_s2);
			nt_s3  <= SW'(nt1_s2) - SW'(nt2_s2);
		end
	end

	// Stage 4: crossing test, foot selection and divider operands.
	// Lane 2k+a divides for candidate k, axis a; on a crossing, lanes 0 and 1
	// carry the crossing point instead.
	logic                 dpos, dneg, in_ns, in_nt, cross_c;
	logic signed [SW-1:0] ndt, nte, dab;
	logic signed [SW-1:0] num_c [8];
	logic signed [SW-1:0] mag_c [8];
	logic signed [C:0]    av_c [8];
	logic signed [C:0]    amag_c [8];
	ssd_pkg::foot_sel_t   mode_c [4];

	logic signed [C-1:0]  pt_s4 [4][2];
	logic [DVW-1:0]       un_s4 [8];
	logic [AW-1:0]        ua_s4 [8];
	logic [DVW-1:0]       dv_s4 [8];
	logic [7:0]           neg_s4;
	ssd_pkg::foot_sel_t   mode_s4 [4];
	logic                 cross_s4;

	always_comb begin
		dpos  = !den_s3[SW-1] && (den_s3 != '0);
		dneg  = den_s3[SW-1];
		ndt   = -den_s3;
		in_ns = dpos ? (!ns_s3[SW-1] && (ns_s3 <= den_s3))
			: (dneg && (ns_s3[SW-1] || (ns_s3 == '0)) && (ns_s3 >= den_s3));
		in_nt = dneg ? (!nt_s3[SW-1] && (nt_s3 <= ndt))
			: (dpos && (nt_s3[SW-1] || (nt_s3 == '0)) && (nt_s3 >= ndt));
		cross_c = in_ns && in_nt;
		nte = dpos ? -nt_s3 : nt_s3;
		dab = dpos ? den_s3 : ndt;
		for (int k = 0; k < 4; k++) begin
			if (((sd_s3[(k < 2) ? 1 : 0][0] == '0) && (sd_s3[(k < 2) ? 1 : 0][1] == '0))
					|| n_s3[k][SW-1]) begin
				mode_c[k] = ssd_pkg::FOOT_START;
			end else if (n_s3[k] > SW'(len_s3[(k < 2) ? 1 : 0])) begin
				mode_c[k] = ssd_pkg::FOOT_END;
			end else begin
				mode_c[k] = ssd_pkg::FOOT_MID;
			end
		end
		for (int ln = 0; ln < 8; ln++) begin
			if (cross_c && (ln < 2)) begin
				num_c[ln] = nte;
				av_c[ln]  = sd_s3[0][ln % 2];
			end else begin
				num_c[ln] = n_s3[ln / 2];
				av_c[ln]  = sd_s3[(ln < 4) ? 1 : 0][ln % 2];
			end
			mag_c[ln]  = num_c[ln][SW-1] ? -num_c[ln] : num_c[ln];
			amag_c[ln] = av_c[ln][C] ? -av_c[ln] : av_c[ln];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s4    <= pt_s3;
			mode_s4  <= mode_c;
			cross_s4 <= cross_c;
			for (int ln = 0; ln < 8; ln++) begin
				un_s4[ln]  <= mag_c[ln][DVW-1:0];
				ua_s4[ln]  <= amag_c[ln];
				neg_s4[ln] <= num_c[ln][SW-1] ^ av_c[ln][C];
				if (cross_c && (ln < 2)) begin
					dv_s4[ln] <= dab[DVW-1:0];
				end else begin
					dv_s4[ln] <= len_s3[(ln < 4) ? 1 : 0];
				end
			end
		end
	end

	// Stage 5: dividend products; side data enters its delay line here.
	logic [NW-1:0]  prod_s5 [8];
	logic [DVW-1:0] dv_s5 [8];
	logic [SDW-1:0] side_c, side_s5, side_d;

	always_comb begin
		side_c = '0;
		for (int i = 0; i < 4; i++) begin
			side_c[i*C +: C]       = pt_s4[i][0];
			side_c[4*C + i*C +: C] = pt_s4[i][1];
			side_c[8*C + 1 + 2*i +: 2] = mode_s4[i];
		end
		side_c[8*C] = cross_s4;
		side_c[8*C + 9 +: 8] = neg_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_c;
			for (int ln = 0; ln < 8; ln++) begin
				prod_s5[ln] <= un_s4[ln] * ua_s4[ln];
				dv_s5[ln]   <= dv_s4[ln];
			end
		end
	end

	ssd_delay #(.W(SDW), .N(QW)) u_side_div (
		.clk (clk),
		.en  (en),
		.d   (side_s5),
		.q   (side_d)
	);

	// Eight divider lanes, each a row of QW cells, most significant bit first.
	logic [NW-1:0]  dr [8][QW+1];
	logic [DVW-1:0] dd [8][QW+1];
	logic [QW-1:0]  dq [8][QW+1];

	for (genvar ln = 0; ln < 8; ln++) begin : g_lane
		assign dr[ln][0] = prod_s5[ln];
		assign dd[ln][0] = dv_s5[ln];
		assign dq[ln][0] = '0;
		for (genvar j = 0; j < QW; j++) begin : g_cell
			ssd_div_cell #(.NW(NW), .DVW(DVW), .QW(QW), .IDX(QW-1-j)) u_cell (
				.clk (clk),
				.en  (en),
				.r_i (dr[ln][j]),
				.d_i (dd[ln][j]),
				.q_i (dq[ln][j]),
				.r_o (dr[ln][j+1]),
				.d_o (dd[ln][j+1]),
				.q_o (dq[ln][j+1])
			);
		end
	end

	// Stage 6: feet. The exact foot is truncated toward zero: floor of the
	// signed quotient, then one step up when inexact and negative.
	logic signed [C-1:0]  ptd [4][2];
	ssd_pkg::foot_sel_t   moded [4];
	logic                 crossd;
	logic signed [FW-1:0] fl_c [8];
	logic signed [FW-1:0] base_c [8];
	logic signed [FW-1:0] adj_c [8];
	logic signed [C-1:0]  sc_c [8];
	logic                 rnz_c [8];
	logic signed [C-1:0]  ft_c [4][2];

	logic signed [C-1:0]  pt_s6 [4][2];
	logic signed [C-1:0]  ft_s6 [4][2];
	logic                 cross_s6;

	always_comb begin
		crossd = side_d[8*C];
		for (int i = 0; i < 4; i++) begin
			ptd[i][0] = side_d[i*C +: C];
			ptd[i][1] = side_d[4*C + i*C +: C];
			moded[i]  = ssd_pkg::foot_sel_t'(side_d[8*C + 1 + 2*i +: 2]);
		end
		for (int ln = 0; ln < 8; ln++) begin
			rnz_c[ln] = (dr[ln][QW] != '0);
			if (crossd && (ln < 2)) begin
				sc_c[ln] = ptd[0][ln % 2];
			end else begin
				sc_c[ln] = ptd[(ln < 4) ? 2 : 0][ln % 2];
			end
			if (side_d[8*C + 9 + ln]) begin
				fl_c[ln] = -FW'(dq[ln][QW]) - FW'(rnz_c[ln]);
			end else begin
				fl_c[ln] = FW'(dq[ln][QW]);
			end
			base_c[ln] = FW'(sc_c[ln]) + fl_c[ln];
			adj_c[ln]  = (rnz_c[ln] && base_c[ln][FW-1]) ? (base_c[ln] + FW'(1)) : base_c[ln];
		end
		for (int k = 0; k < 4; k++) begin
			for (int a = 0; a < 2; a++) begin
				if ((crossd && (k == 0)) || (moded[k] == ssd_pkg::FOOT_MID)) begin
					ft_c[k][a] = adj_c[2*k+a][C-1:0];
				end else if (moded[k] == ssd_pkg::FOOT_END) begin
					ft_c[k][a] = ptd[(k < 2) ? 3 : 1][a];
				end else begin
					ft_c[k][a] = ptd[(k < 2) ? 2 : 0][a];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s6    <= ptd;
			ft_s6    <= ft_c;
			cross_s6 <= crossd;
		end
	end

	// Stage 7: squared offsets from each projected point to its foot.
	logic signed [C:0]   off_c [4][2];
	logic signed [C-1:0] pt_s7 [4][2];
	logic signed [C-1:0] ft_s7 [4][2];
	logic [PW-1:0]       sq_s7 [4][2];
	logic                cross_s7;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			for (int a = 0; a < 2; a++) begin
				off_c[k][a] = {pt_s6[k][a][C-1], pt_s6[k][a]}
					- {ft_s6[k][a][C-1], ft_s6[k][a]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s7    <= pt_s6;
			ft_s7    <= ft_s6;
			cross_s7 <= cross_s6;
			for (int k = 0; k < 4; k++) begin
				for (int a = 0; a < 2; a++) begin
					sq_s7[k][a] <= off_c[k][a] * off_c[k][a];
				end
			end
		end
	end

	// Stage 8: squared distance of each candidate.
	logic signed [C-1:0] pt_s8 [4][2];
	logic signed [C-1:0] ft_s8 [4][2];
	logic [DQW-1:0]      sqd_s8 [4];
	logic                cross_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s8    <= pt_s7;
			ft_s8    <= ft_s7;
			cross_s8 <= cross_s7;
			for (int k = 0; k < 4; k++) begin
				sqd_s8[k] <= DQW'(sq_s7[k][0]) + DQW'(sq_s7[k][1]);
			end
		end
	end

	// Stage 9: first level of the minimum; a tie keeps the earlier candidate.
	logic signed [C-1:0] pt_s9 [4][2];
	logic signed [C-1:0] ft_s9 [4][2];
	logic [DQW-1:0]      d01_s9, d23_s9;
	logic                i01_s9, i23_s9, cross_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s9    <= pt_s8;
			ft_s9    <= ft_s8;
			cross_s9 <= cross_s8;
			i01_s9   <= (sqd_s8[1] < sqd_s8[0]);
			d01_s9   <= (sqd_s8[1] < sqd_s8[0]) ? sqd_s8[1] : sqd_s8[0];
			i23_s9   <= (sqd_s8[3] < sqd_s8[2]);
			d23_s9   <= (sqd_s8[3] < sqd_s8[2]) ? sqd_s8[3] : sqd_s8[2];
		end
	end

	// Stage 10: winner, nearest points and the scaled radicand.
	// Candidates 0 and 1 project an endpoint of A, so that endpoint lies on A
	// and the foot on B; candidates 2 and 3 the other way around.
	logic                upper_c;
	logic [1:0]          best_c;
	logic [DQW-1:0]      bestd_c;
	logic signed [C-1:0] na_c [2];
	logic signed [C-1:0] nb_c [2];
	logic [SQI-1:0]      rad_s10;
	logic [S2W-1:0]      side2_c, side2_s10, side2_d;

	always_comb begin
		upper_c = (d23_s9 < d01_s9);
		best_c  = upper_c ? {1'b1, i23_s9} : {1'b0, i01_s9};
		bestd_c = upper_c ? d23_s9 : d01_s9;
		for (int a = 0; a < 2; a++) begin
			if (cross_s9) begin
				na_c[a] = ft_s9[0][a];
				nb_c[a] = ft_s9[0][a];
			end else if (!best_c[1]) begin
				na_c[a] = pt_s9[best_c][a];
				nb_c[a] = ft_s9[best_c][a];
			end else begin
				na_c[a] = ft_s9[best_c][a];
				nb_c[a] = pt_s9[best_c][a];
			end
		end
		side2_c = {cross_s9, nb_c[1], nb_c[0], na_c[1], na_c[0]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s10   <= SQI'(bestd_c) << (2*FRAC_BITS);
			side2_s10 <= side2_c;
		end
	end

	ssd_delay #(.W(S2W), .N(RB)) u_side_sqrt (
		.clk (clk),
		.en  (en),
		.d   (side2_s10),
		.q   (side2_d)
	);

	// Square root row: one root bit per cell, top bit pair first.
	logic [SQI-1:0] sr_rad [RB+1];
	logic [RB+2:0]  sr_rem [RB+1];
	logic [RB-1:0]  sr_root [RB+1];

	assign sr_rad[0]  = rad_s10;
	assign sr_rem[0]  = '0;
	assign sr_root[0] = '0;

	for (genvar j = 0; j < RB; j++) begin : g_sqrt
		ssd_sqrt_cell #(.SQI(SQI), .RB(RB), .IDX(RB-1-j)) u_cell (
			.clk    (clk),
			.en     (en),
			.rad_i  (sr_rad[j]),
			.rem_i  (sr_rem[j]),
			.root_i (sr_root[j]),
			.rad_o  (sr_rad[j+1]),
			.rem_o  (sr_rem[j+1]),
			.root_o (sr_root[j+1])
		);
	end

	// Output register: distance is zero on a crossing; coordinates are sign
	// extended or cut to the output width.
	logic [RB+DSW-1:0]  root_w;
	logic [C+OCW-1:0]   cx_w [4];
	logic [87:0]        tdata_q;
	logic               tuser_q;

	assign root_w = (RB+DSW)'(sr_root[RB]);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cx_w[i] = (C+OCW)'($signed(side2_d[i*C +: C]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tuser_q <= side2_d[4*C];
			tdata_q <= {3'b000, cx_w[3][OCW-1:0], cx_w[2][OCW-1:0], cx_w[1][OCW-1:0],
				cx_w[0][OCW-1:0], side2_d[4*C] ? DSW'(0) : root_w[DSW-1:0]};
		end
	end

	assign m_axis_tdata = tdata_q;
	assign m_axis_tuser = tuser_q;

endmodule

// ----- rtl/core/ssd_delay.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_delay
// Enable-gated register chain that keeps side data aligned with a cell row.
// ----------------------------------------------------------------------------
module ssd_delay #(
	parameter int W = 8,
	parameter int N = 4
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] stg_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			stg_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				stg_q[i] <= stg_q[i-1];
			end
		end
	end

	assign q = stg_q[N-1];

endmodule

// ----- rtl/core/ssd_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_div_cell
// One restoring division step: settles quotient bit IDX and passes on.
// ----------------------------------------------------------------------------
module ssd_div_cell #(
	parameter int NW  = 51,
	parameter int DVW = 35,
	parameter int QW  = 17,
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NW-1:0]  r_i,
	input  logic [DVW-1:0] d_i,
	input  logic [QW-1:0]  q_i,
	output logic [NW-1:0]  r_o,
	output logic [DVW-1:0] d_o,
	output logic [QW-1:0]  q_o
);

	logic [NW-1:0] dsh;
	logic          ge;

	assign dsh = NW'(d_i) << IDX;
	assign ge  = (r_i >= dsh);

	always_ff @(posedge clk) begin
		if (en) begin
			r_o <= ge ? (r_i - dsh) : r_i;
			d_o <= d_i;
			q_o <= q_i | (QW'(ge) << IDX);
		end
	end

endmodule

// ----- rtl/core/ssd_sqrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_sqrt_cell
// One digit-by-digit square root step: consumes radicand bit pair IDX.
// ----------------------------------------------------------------------------
module ssd_sqrt_cell #(
	parameter int SQI = 44,
	parameter int RB  = 22,
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           en,
	input  logic [SQI-1:0] rad_i,
	input  logic [RB+2:0]  rem_i,
	input  logic [RB-1:0]  root_i,
	output logic [SQI-1:0] rad_o,
	output logic [RB+2:0]  rem_o,
	output logic [RB-1:0]  root_o
);

	logic [RB+2:0] remn;
	logic [RB+2:0] trial;
	logic          ge;

	assign remn  = {rem_i[RB:0], rad_i[2*IDX +: 2]};
	assign trial = {1'b0, root_i, 2'b01};
	assign ge    = (remn >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o  <= rad_i;
			rem_o  <= ge ? (remn - trial) : remn;
			root_o <= {root_i[RB-2:0], ge};
		end
	end

endmodule

// ----- sim/segment_to_segment_distance_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_to_segment_distance_unit_tb
// Self-checking bench for the segment distance pipeline. Segment pairs go in
// through the input stream, and a local integer model predicts each gap,
// crossing flag and pair of nearest points. Both stream sides are throttled
// at random, and one long output stall backs the pipeline up.
// ----------------------------------------------------------------------------
module segment_to_segment_distance_unit_tb;

	localparam int CB         = 16;
	localparam int FB         = 4;
	localparam int LATENCY    = 50;
	localparam int STALL_LEN  = 300;
	localparam int IDLE_LIMIT = 20000;

	// Stimulus shapes for the random part.
	typedef enum int {
		MIX_WIDE, MIX_SMALL, MIX_CROSS, MIX_PARALLEL, MIX_POINT, MIX_SHARED
	} mix_t;

	typedef struct packed {
		logic signed [CB-1:0] bey, bex, bsy, bsx, aey, aex, asy, asx;
	} seg_pair_t;

	typedef struct {
		logic [ssd_pkg::DIST_W-1:0]      gap;
		logic                            crossed;
		logic [ssd_pkg::OUT_COORD_W-1:0] ax, ay, bx, by;
	} gap_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic [8*CB-1:0]   s_axis_tdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [87:0]       m_axis_tdata;
	logic              m_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;

	gap_result_t gap_expected_q[$];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	bit          stall_req = 1'b0;
	int          stall_left = 0;
	int          mismatch_count = 0;
	int          pairs_sent = 0;
	int          results_seen = 0;
	int          crossings_seen = 0;
	int          idle_cycles = 0;

	segment_to_segment_distance_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	// Truncation toward zero of s + n*a/d, for d > 0.
	function automatic longint trunc_foot(longint s, longint n, longint a, longint d);
		longint p, q, r, base;
		p = n * a;
		q = p / d;
		r = p % d;
		if (r != 0 && p < 0)
			q = q - 1;
		base = s + q;
		if (r != 0 && base < 0)
			base = base + 1;
		return base;
	endfunction

	// Squared distance from point (px,py) to segment s-e; the foot is returned.
	function automatic longint seg_project(longint px, longint py, longint sx, longint sy,
			longint ex, longint ey, output longint fx, output longint fy);
		longint dx, dy, len, n;
		dx = ex - sx;
		dy = ey - sy;
		fx = sx;
		fy = sy;
		if (dx != 0 || dy != 0) begin
			len = dx * dx + dy * dy;
			n = (px - sx) * dx + (py - sy) * dy;
			if (n > len) begin
				fx = ex;
				fy = ey;
			end else if (n >= 0) begin
				fx = trunc_foot(sx, n, dx, len);
				fy = trunc_foot(sy, n, dy, len);
			end
		end
		return (px - fx) * (px - fx) + (py - fy) * (py - fy);
	endfunction

	function automatic bit param_in_unit(longint n, longint d);
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		return n >= 0 && n <= d;
	endfunction

	function automatic longint root_floor(longint v);
		longint r, bitv;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			bitv = longint'(1) << i;
			if ((r + bitv) * (r + bitv) <= v)
				r = r + bitv;
		end
		return r;
	endfunction

	function automatic gap_result_t gap_predict(seg_pair_t sp);
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		longint dxa, dya, dxb, dyb, den, ns, nt, dt;
		longint best, cur, fx, fy, nax, nay, nbx, nby;
		gap_result_t res;
		ax0 = sp.asx; ay0 = sp.asy; ax1 = sp.aex; ay1 = sp.aey;
		bx0 = sp.bsx; by0 = sp.bsy; bx1 = sp.bex; by1 = sp.bey;
		dxa = ax1 - ax0; dya = ay1 - ay0;
		dxb = bx1 - bx0; dyb = by1 - by0;
		den = dxb * dya - dyb * dxa;
		res.crossed = 1'b0;
		res.gap = '0;
		if (den != 0) begin
			ns = dxa * (by0 - ay0) + dya * (ax0 - bx0);
			nt = dxb * (ay0 - by0) + dyb * (bx0 - ax0);
			dt = -den;
			if (param_in_unit(ns, den) && param_in_unit(nt, dt)) begin
				if (dt < 0) begin
					nt = -nt;
					dt = -dt;
				end
				res.crossed = 1'b1;
				nax = trunc_foot(ax0, nt, dxa, dt);
				nay = trunc_foot(ay0, nt, dya, dt);
				nbx = nax;
				nby = nay;
			end
		end
		if (!res.crossed) begin
			// Candidates in fixed order; a tie keeps the earlier one.
			best = seg_project(ax0, ay0, bx0, by0, bx1, by1, fx, fy);
			nax = ax0; nay = ay0; nbx = fx; nby = fy;
			cur = seg_project(ax1, ay1, bx0, by0, bx1, by1, fx, fy);
			if (cur < best) begin
				best = cur; nax = ax1; nay = ay1; nbx = fx; nby = fy;
			end
			cur = seg_project(bx0, by0, ax0, ay0, ax1, ay1, fx, fy);
			if (cur < best) begin
				best = cur; nax = fx; nay = fy; nbx = bx0; nby = by0;
			end
			cur = seg_project(bx1, by1, ax0, ay0, ax1, ay1, fx, fy);
			if (cur < best) begin
				best = cur; nax = fx; nay = fy; nbx = bx1; nby = by1;
			end
			res.gap = ssd_pkg::DIST_W'(root_floor(best << (2 * FB)));
		end
		res.ax = ssd_pkg::OUT_COORD_W'(nax);
		res.ay = ssd_pkg::OUT_COORD_W'(nay);
		res.bx = ssd_pkg::OUT_COORD_W'(nbx);
		res.by = ssd_pkg::OUT_COORD_W'(nby);
		return res;
	endfunction

	// ------------------------------------------------------------- checking

	task automatic report_mismatch(string field, longint got, longint want);
		mismatch_count++;
		$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
	endtask

	// Every accepted input item queues its prediction.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			gap_expected_q.push_back(gap_predict(seg_pair_t'(s_axis_tdata)));
	end

	// Every accepted result is held against the oldest prediction.
	always @(posedge clk) begin
		gap_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (gap_expected_q.size() == 0) begin
				report_mismatch("result items outstanding", 1, 0);
			end else begin
				want = gap_expected_q.pop_front();
				if (want.crossed)
					crossings_seen++;
				if (m_axis_tdata[20:0] !== want.gap)
					report_mismatch("gap_distance", m_axis_tdata[20:0], want.gap);
				if (m_axis_tuser !== want.crossed)
					report_mismatch("crossing", m_axis_tuser, want.crossed);
				if (m_axis_tdata[36:21] !== want.ax)
					report_mismatch("near_a_x", m_axis_tdata[36:21], want.ax);
				if (m_axis_tdata[52:37] !== want.ay)
					report_mismatch("near_a_y", m_axis_tdata[52:37], want.ay);
				if (m_axis_tdata[68:53] !== want.bx)
					report_mismatch("near_b_x", m_axis_tdata[68:53], want.bx);
				if (m_axis_tdata[84:69] !== want.by)
					report_mismatch("near_b_y", m_axis_tdata[84:69], want.by);
			end
		end
	end

	// Output throttle, with one long stall that fills the pipeline.
	always @(negedge clk) begin
		if (stall_req) begin
			stall_left = STALL_LEN;
			stall_req = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Watchdog on cycles with no traffic on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
			$display("segment_to_segment_distance_unit regression: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------- stimulus

	// Offers one pair and returns once it is taken; tvalid stays high after.
	task automatic send_pair(seg_pair_t sp);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata = sp;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pairs_sent++;
	endtask

	task automatic send_coords(int asx, int asy, int aex, int aey,
			int bsx, int bsy, int bex, int bey);
		seg_pair_t sp;
		sp.asx = CB'(asx); sp.asy = CB'(asy); sp.aex = CB'(aex); sp.aey = CB'(aey);
		sp.bsx = CB'(bsx); sp.bsy = CB'(bsy); sp.bex = CB'(bex); sp.bey = CB'(bey);
		send_pair(sp);
	endtask

	function automatic logic [CB-1:0] near_coord(int center, int spread);
		int v;
		v = center + $urandom_range(0, 2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return CB'(v);
	endfunction

	function automatic seg_pair_t random_pair(mix_t mix);
		seg_pair_t sp;
		int cx, cy, dx, dy, k;
		sp = {$urandom, $urandom, $urandom, $urandom};
		cx = $signed(CB'($urandom));
		cy = $signed(CB'($urandom));
		case (mix)
			MIX_WIDE: begin
			end
			MIX_SMALL: begin
				sp.asx = near_coord(cx, 40); sp.asy = near_coord(cy, 40);
				sp.aex = near_coord(cx, 40); sp.aey = near_coord(cy, 40);
				sp.bsx = near_coord(cx, 40); sp.bsy = near_coord(cy, 40);
				sp.bex = near_coord(cx, 40); sp.bey = near_coord(cy, 40);
			end
			MIX_CROSS: begin
				// Endpoints on opposite sides of a common center.
				cx = cx / 2; cy = cy / 2;
				dx = $urandom_range(1, 9000); dy = $urandom_range(0, 9000);
				sp.asx = CB'(cx - dx); sp.asy = CB'(cy - dy);
				sp.aex = CB'(cx + dx); sp.aey = CB'(cy + dy);
				dx = $urandom_range(0, 9000); dy = $urandom_range(1, 9000);
				sp.bsx = CB'(cx + dx); sp.bsy = CB'(cy - dy);
				sp.bex = CB'(cx - dx); sp.bey = CB'(cy + dy);
			end
			MIX_PARALLEL: begin
				cx = cx / 2; cy = cy / 2;
				dx = $urandom_range(0, 4000) - 2000; dy = $urandom_range(0, 4000) - 2000;
				k = $urandom_range(0, 3);
				sp.asx = CB'(cx); sp.asy = CB'(cy);
				sp.aex = CB'(cx + dx); sp.aey = CB'(cy + dy);
				sp.bsx = near_coord(cx, k * 3000); sp.bsy = near_coord(cy, k * 3000);
				if (k == 0) begin
					// Collinear with A.
					sp.bsx = CB'(cx + 2 * dx); sp.bsy = CB'(cy + 2 * dy);
				end
				sp.bex = CB'($signed(sp.bsx) - 3 * dx);
				sp.bey = CB'($signed(sp.bsy) - 3 * dy);
			end
			MIX_POINT: begin
				sp.aex = sp.asx; sp.aey = sp.asy;
				if ($urandom_range(0, 2) == 0) begin
					sp.bex = sp.bsx; sp.bey = sp.bsy;
				end
				if ($urandom_range(0, 1)) begin
					sp = {sp.aey, sp.aex, sp.asy, sp.asx, sp.bey, sp.bex, sp.bsy, sp.bsx};
				end
			end
			MIX_SHARED: begin
				// B starts on an endpoint of A, or on A's interior.
				sp.asx = near_coord(cx, 5000); sp.asy = near_coord(cy, 5000);
				sp.aex = near_coord(cx, 5000); sp.aey = near_coord(cy, 5000);
				if ($urandom_range(0, 1)) begin
					sp.bsx = sp.aex; sp.bsy = sp.aey;
				end else begin
					sp.bsx = CB'((int'(sp.asx) + int'(sp.aex)) / 2);
					sp.bsy = CB'((int'(sp.asy) + int'(sp.aey)) / 2);
				end
				sp.bex = near_coord($signed(sp.bsx), 5000);
				sp.bey = near_coord($signed(sp.bsy), 5000);
			end
		endcase
		return sp;
	endfunction

	task automatic run_random(int count);
		int pick;
		mix_t mix;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) mix = MIX_WIDE;
			else if (pick < 45) mix = MIX_SMALL;
			else if (pick < 65) mix = MIX_CROSS;
			else if (pick < 77) mix = MIX_PARALLEL;
			else if (pick < 88) mix = MIX_POINT;
			else mix = MIX_SHARED;
			send_pair(random_pair(mix));
		end
	endtask

	// Extremes, crossings, touching ends, parallel and degenerate segments.
	task automatic test_directed();
		send_coords(-10, 0, 10, 0, 0, -10, 0, 10);
		send_coords(-7, -3, 8, 5, 6, -9, -5, 4);
		send_coords(0, 0, 10, 0, 10, 0, 10, 10);
		send_coords(0, 0, 10, 0, 5, 0, 5, 7);
		send_coords(0, 0, 10, 0, 0, 3, 10, 3);
		send_coords(0, 0, 10, 0, 5, 0, 20, 0);
		send_coords(0, 0, 10, 0, 15, 0, 20, 0);
		send_coords(3, 4, 3, 4, 3, 4, 3, 4);
		send_coords(0, 0, 0, 0, 3, 4, 3, 4);
		send_coords(1, 1, 1, 1, -5, 7, 9, -2);
		send_coords(-5, 7, 9, -2, 2, 2, 2, 2);
		send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_coords(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
		send_coords(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768);
		send_coords(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
		send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_coords(-32768, -32768, -32767, -32768, 0, 0, 1, 1);
		send_coords(-9, -9, -1, -2, -20, -1, 3, -17);
		send_coords(0, 0, 7, 3, 2, 5, 9, 8);
		send_coords(0, 0, 7, 3, 9, 8, 2, 5);
		send_coords(5, 5, 100, 7, -3, 40, 60, 9);
		send_coords(0, 0, 4, 4, 4, 4, 8, 0);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct = 35;
		recv_idle_pct = 59;
		run_random(630);
	endtask

	// Long output stall while input keeps coming; then the receiver-heavy mix.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_req = 1'b1;
		run_random(150);
		send_idle_pct = 59;
		recv_idle_pct = 35;
		run_random(480);
	endtask

	task automatic test_full_rate();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(630);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		recv_idle_pct = 0;
		wait (gap_expected_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_sender_gaps();
		test_backpressure();
		test_full_rate();
		drain();
		$display("Covered %0d segment pairs (%0d proper crossings) under sender and receiver",
			pairs_sent, crossings_seen);
		$display("throttling, one %0d-cycle output stall and full rate; %0d mismatches.",
			STALL_LEN, mismatch_count);
		if (mismatch_count == 0 && gap_expected_q.size() == 0 && results_seen == pairs_sent)
			$display("segment_to_segment_distance_unit regression: pass");
		else
			$display("segment_to_segment_distance_unit regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/ssd_pkg.sv
rtl/core/ssd_delay.sv
rtl/core/ssd_div_cell.sv
rtl/core/ssd_sqrt_cell.sv
rtl/core/segment_to_segment_distance_unit.sv
sim/segment_to_segment_distance_unit_tb.sv
